### design/ptq_pkg.sv
// ----------------------------------------------------------------------------
// ptq_pkg
// Shared types and codes for the multilevel priority task queue.
// ----------------------------------------------------------------------------
package ptq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int NUM_LEVELS  = 4;

    localparam int ID_W    = 8;
    localparam int PRIO_W  = 3;
    localparam int ENTRY_W = ID_W + PRIO_W;

    // operation codes
    localparam logic [1:0] OP_ENQUEUE = 2'd0;
    localparam logic [1:0] OP_DEQUEUE = 2'd1;
    localparam logic [1:0] OP_MOVE    = 2'd2;
    localparam logic [1:0] OP_RESTORE = 2'd3;

    // status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_PRIO   = 3'd1;
    localparam logic [2:0] ST_FULL       = 3'd2;
    localparam logic [2:0] ST_ALL_EMPTY  = 3'd3;
    localparam logic [2:0] ST_PEND_EMPTY = 3'd4;
    localparam logic [2:0] ST_DROPPED    = 3'd5;

    typedef struct packed {
        logic [1:0]        op;
        logic [ID_W-1:0]   task_id;
        logic [PRIO_W-1:0] task_priority;
    } req_t;

    typedef struct packed {
        logic              success;
        logic [2:0]        status;
        logic [ID_W-1:0]   out_task_id;
        logic [PRIO_W-1:0] out_task_priority;
    } rsp_t;

endpackage

### design/ptq_ram.sv
// ----------------------------------------------------------------------------
// ptq_ram
// Single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module ptq_ram #(
    parameter int WIDTH = ptq_pkg::ENTRY_W,
    parameter int DEPTH = ptq_pkg::QUEUE_DEPTH
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### design/priority_task_queue_unit.sv
// ----------------------------------------------------------------------------
// priority_task_queue_unit
// NUM_LEVELS FIFO task queues by priority (0 highest) plus a pending FIFO.
//
// Request channel (req_valid / req_stall / req): one item per operation:
// enqueue, dequeue, move to pending, restore from pending. Response channel
// (rsp_valid / rsp_stall / rsp): exactly one item per request, in order,
// with success, status and the task popped or restored.
// All queue entries live in one RAM, addressed {queue, slot}; head, tail and
// count per queue are flops. An accepted item is handled in order:
// the accept cycle issues the RAM read of the relevant queue head, then
// the execute state does the update and write-back and loads the response
// register once the output register is free. No new request is accepted
// until the item being finished leaves the execute state.
// A new request is taken while a response still waits in the output
// register. If the receiver stalls, the item being finished holds until
// the output register frees, and req_stall stays high meanwhile.
// Reset empties every queue at once (no clearing pass); RAM contents are
// not cleared, since data read from unwritten entries is never used.
// ----------------------------------------------------------------------------
module priority_task_queue_unit #(
    parameter int QUEUE_DEPTH = ptq_pkg::QUEUE_DEPTH,
    parameter int NUM_LEVELS  = ptq_pkg::NUM_LEVELS
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  ptq_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output ptq_pkg::rsp_t rsp
);

    localparam int NUM_QUEUES = NUM_LEVELS + 1;
    localparam int QW         = $clog2(NUM_QUEUES);
    localparam int SW         = $clog2(QUEUE_DEPTH);
    localparam int CW         = $clog2(QUEUE_DEPTH + 1);
    localparam int AW         = QW + SW;
    localparam int MEM_DEPTH  = NUM_QUEUES * (2 ** SW);
    localparam logic [QW-1:0] PEND_Q = QW'(NUM_LEVELS);

    typedef enum logic {S_IDLE, S_EXEC} state_t;

    state_t state_reg, state_next;
    ptq_pkg::req_t req_reg;
    ptq_pkg::rsp_t rsp_reg, rsp_next;
    logic          rsp_valid_reg, rsp_valid_next;

    logic [SW-1:0] head_reg [NUM_QUEUES];
    logic [SW-1:0] head_next [NUM_QUEUES];
    logic [SW-1:0] tail_reg [NUM_QUEUES];
    logic [SW-1:0] tail_next [NUM_QUEUES];
    logic [CW-1:0] cnt_reg [NUM_QUEUES];
    logic [CW-1:0] cnt_next [NUM_QUEUES];

    logic [NUM_QUEUES-1:0] full_vec;
    logic [NUM_QUEUES-1:0] empty_vec;
    logic [QW-1:0]         deq_q;
    logic                  deq_found;

    logic                        accept;
    logic                        exec_go;
    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic [ptq_pkg::ENTRY_W-1:0] rd_data;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [ptq_pkg::ENTRY_W-1:0] wr_data;
    logic [QW-1:0]               wr_q;

    logic [ptq_pkg::PRIO_W-1:0] enq_prio;
    logic [ptq_pkg::PRIO_W-1:0] rst_prio;
    logic [QW-1:0]              enq_q;
    logic [QW-1:0]              rst_q;
    logic                       enq_prio_ok;
    logic                       rst_prio_ok;

    function automatic logic [SW-1:0] ptr_inc(input logic [SW-1:0] p);
        if (p == SW'(QUEUE_DEPTH - 1))
        begin
            return '0;
        end
        return p + SW'(1);
    endfunction

    // occupancy flags
    always_comb
    begin
        for (int i = 0; i < NUM_QUEUES; i++)
        begin
            full_vec[i]  = (cnt_reg[i] == CW'(QUEUE_DEPTH));
            empty_vec[i] = (cnt_reg[i] == '0);
        end
    end

    // highest non-empty level
    always_comb
    begin
        deq_q     = '0;
        deq_found = 1'b0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--)
        begin
            if (!empty_vec[i])
            begin
                deq_q     = QW'(i);
                deq_found = 1'b1;
            end
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign exec_go   = (state_reg == S_EXEC) && (!rsp_valid_reg || !rsp_stall);

    // head read issued on accept; state does not change until the item
    // completes, so no forwarding is needed
    assign rd_en   = accept;
    assign rd_addr = (req.op == ptq_pkg::OP_DEQUEUE) ? {deq_q, head_reg[deq_q]}
                                                     : {PEND_Q, head_reg[PEND_Q]};

    assign enq_prio    = req_reg.task_priority;
    assign rst_prio    = rd_data[ptq_pkg::ENTRY_W-1:ptq_pkg::ID_W];
    assign enq_prio_ok = (32'(enq_prio) < NUM_LEVELS);
    assign rst_prio_ok = (32'(rst_prio) < NUM_LEVELS);
    assign enq_q       = QW'(enq_prio);
    assign rst_q       = QW'(rst_prio);

    assign wr_addr = {wr_q, tail_reg[wr_q]};

    always_comb
    begin
        state_next     = state_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        head_next      = head_reg;
        tail_next      = tail_reg;
        cnt_next       = cnt_reg;
        wr_en          = 1'b0;
        wr_q           = PEND_Q;
        wr_data        = {req_reg.task_priority, req_reg.task_id};

        if (accept)
        begin
            state_next = S_EXEC;
        end

        if (exec_go)
        begin
            state_next     = S_IDLE;
            rsp_valid_next = 1'b1;
            rsp_next       = '0;
            rsp_next.status = ptq_pkg::ST_OK;
            case (req_reg.op)
                ptq_pkg::OP_ENQUEUE:
                begin
                    if (!enq_prio_ok)
                    begin
                        rsp_next.status = ptq_pkg::ST_BAD_PRIO;
                    end
                    else if (full_vec[enq_q])
                    begin
                        rsp_next.status = ptq_pkg::ST_FULL;
                    end
                    else
                    begin
                        wr_en            = 1'b1;
                        wr_q             = enq_q;
                        tail_next[enq_q] = ptr_inc(tail_reg[enq_q]);
                        cnt_next[enq_q]  = cnt_reg[enq_q] + CW'(1);
                    end
                end
                ptq_pkg::OP_DEQUEUE:
                begin
                    if (!deq_found)
                    begin
                        rsp_next.status = ptq_pkg::ST_ALL_EMPTY;
                    end
                    else
                    begin
                        head_next[deq_q] = ptr_inc(head_reg[deq_q]);
                        cnt_next[deq_q]  = cnt_reg[deq_q] - CW'(1);
                        rsp_next.out_task_id       = rd_data[ptq_pkg::ID_W-1:0];
                        rsp_next.out_task_priority = rst_prio;
                    end
                end
                ptq_pkg::OP_MOVE:
                begin
                    if (full_vec[PEND_Q])
                    begin
                        rsp_next.status = ptq_pkg::ST_FULL;
                    end
                    else
                    begin
                        wr_en             = 1'b1;
                        wr_q              = PEND_Q;
                        tail_next[PEND_Q] = ptr_inc(tail_reg[PEND_Q]);
                        cnt_next[PEND_Q]  = cnt_reg[PEND_Q] + CW'(1);
                    end
                end
                ptq_pkg::OP_RESTORE:
                begin
                    if (empty_vec[PEND_Q])
                    begin
                        rsp_next.status = ptq_pkg::ST_PEND_EMPTY;
                    end
                    else
                    begin
                        head_next[PEND_Q] = ptr_inc(head_reg[PEND_Q]);
                        cnt_next[PEND_Q]  = cnt_reg[PEND_Q] - CW'(1);
                        rsp_next.out_task_id       = rd_data[ptq_pkg::ID_W-1:0];
                        rsp_next.out_task_priority = rst_prio;
                        // pending pop stands even when the re-enqueue fails
                        if (!rst_prio_ok || full_vec[rst_q])
                        begin
                            rsp_next.status = ptq_pkg::ST_DROPPED;
                        end
                        else
                        begin
                            wr_en            = 1'b1;
                            wr_q             = rst_q;
                            wr_data          = rd_data;
                            tail_next[rst_q] = ptr_inc(tail_reg[rst_q]);
                            cnt_next[rst_q]  = cnt_reg[rst_q] + CW'(1);
                        end
                    end
                end
                default:
                begin
                    rsp_next.status = ptq_pkg::ST_OK;
                end
            endcase
            rsp_next.success = (rsp_next.status == ptq_pkg::ST_OK);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    ptq_ram #(
        .WIDTH (ptq_pkg::ENTRY_W),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_EXEC))
        else $error("accepted item did not enter execute");

    a_write_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !full_vec[wr_q])
        else $error("write into a full queue");

    generate
        for (genvar g = 0; g < NUM_QUEUES; g++)
        begin : g_chk
            a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
                cnt_reg[g] <= CW'(QUEUE_DEPTH))
                else $error("queue count over depth");

            a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
                (head_reg[g] == tail_reg[g]) |->
                    (empty_vec[g] || full_vec[g]))
                else $error("pointers equal but queue partly filled");
        end
    endgenerate

endmodule

### tb/sv/ptq_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ptq_checker
// Watches the request and response channels of the priority task queue.
// Keeps its own copy of every level queue and the pending queue, works out
// the response to each accepted request and compares the responses in order.
// ----------------------------------------------------------------------------
module ptq_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic          req_stall,
    input  ptq_pkg::req_t req,
    input  logic          rsp_valid,
    input  logic          rsp_stall,
    input  ptq_pkg::rsp_t rsp,
    output int            mismatches,
    output int            outstanding
);

    import ptq_pkg::*;

    localparam int PEND_Q = NUM_LEVELS;
    localparam int NUM_Q  = NUM_LEVELS + 1;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [ID_W-1:0]   id;
    } task_t;

    task_t store [NUM_Q][QUEUE_DEPTH];
    int    head  [NUM_Q];
    int    tail  [NUM_Q];
    int    fill  [NUM_Q];
    rsp_t  expected_rsp [$];
    int    fail_total = 0;

    function automatic bit ring_push(int q, task_t t);
        if (fill[q] >= QUEUE_DEPTH)
            return 1'b0;
        store[q][tail[q]] = t;
        tail[q] = (tail[q] + 1) % QUEUE_DEPTH;
        fill[q]++;
        return 1'b1;
    endfunction

    function automatic task_t ring_pop(int q);
        task_t t;
        t = store[q][head[q]];
        head[q] = (head[q] + 1) % QUEUE_DEPTH;
        fill[q]--;
        return t;
    endfunction

    function automatic logic [2:0] place_by_priority(task_t t);
        if (t.prio >= NUM_LEVELS)
            return ST_BAD_PRIO;
        return ring_push(int'(t.prio), t) ? ST_OK : ST_FULL;
    endfunction

    // Applies one request to the shadow queues and returns its response.
    function automatic rsp_t schedule_op(req_t r);
        rsp_t  o;
        task_t t;
        task_t shown;
        t.prio = r.task_priority;
        t.id   = r.task_id;
        shown  = '0;
        o      = '0;
        case (r.op)
            OP_ENQUEUE:
                o.status = place_by_priority(t);
            OP_DEQUEUE:
            begin
                o.status = ST_ALL_EMPTY;
                for (int q = 0; q < NUM_LEVELS; q++)
                begin
                    if (o.status == ST_ALL_EMPTY && fill[q] != 0)
                    begin
                        shown    = ring_pop(q);
                        o.status = ST_OK;
                    end
                end
            end
            OP_MOVE:
                o.status = ring_push(PEND_Q, t) ? ST_OK : ST_FULL;
            default:
            begin
                if (fill[PEND_Q] == 0)
                    o.status = ST_PEND_EMPTY;
                else
                begin
                    // pending pop stands even when the task is dropped
                    shown    = ring_pop(PEND_Q);
                    o.status = (place_by_priority(shown) == ST_OK) ? ST_OK : ST_DROPPED;
                end
            end
        endcase
        o.success           = (o.status == ST_OK);
        o.out_task_id       = shown.id;
        o.out_task_priority = shown.prio;
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        rsp_t want;
        if (!rst_n)
        begin
            for (int q = 0; q < NUM_Q; q++)
            begin
                head[q] = 0;
                tail[q] = 0;
                fill[q] = 0;
            end
            expected_rsp.delete();
            mismatches  <= fail_total;
            outstanding <= 0;
        end
        else
        begin
            // a response always belongs to an earlier request, so check first
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsp.size() == 0)
                begin
                    $error("response with none expected: %h", rsp);
                    fail_total++;
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    if (rsp.success !== want.success)
                    begin
                        $error("success: expected %0d, got %0d", want.success, rsp.success);
                        fail_total++;
                    end
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp.status);
                        fail_total++;
                    end
                    if (rsp.out_task_id !== want.out_task_id)
                    begin
                        $error("out_task_id: expected %0d, got %0d",
                               want.out_task_id, rsp.out_task_id);
                        fail_total++;
                    end
                    if (rsp.out_task_priority !== want.out_task_priority)
                    begin
                        $error("out_task_priority: expected %0d, got %0d",
                               want.out_task_priority, rsp.out_task_priority);
                        fail_total++;
                    end
                end
            end
            if (req_valid && !req_stall)
                expected_rsp.push_back(schedule_op(req));
            mismatches  <= fail_total;
            outstanding <= expected_rsp.size();
        end
    end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the priority task queue: a short directed run through the
// empty, bad-priority and drop cases, then random bursts that fill and drain
// the level and pending queues, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb;

    import ptq_pkg::*;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    int mismatches;
    int outstanding;
    bit steady = 1'b0;   // no idling on either side while set

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    priority_task_queue_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    ptq_checker queue_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    task automatic send_op(logic [1:0] op, logic [ID_W-1:0] id, logic [PRIO_W-1:0] prio);
        req_t r;
        int   gap;
        r.op            = op;
        r.task_id       = id;
        r.task_priority = prio;
        gap = steady ? 0 : $urandom_range(0, 19);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (req_stall) @(posedge clk);
    endtask

    initial
    begin : drain_rsp
        int hold;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            hold = steady ? 0 : $urandom_range(0, 19);
            if (hold != 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            @(posedge clk);
            while (!rsp_valid) @(posedge clk);
        end
    end

    initial
    begin : stimulus
        int         sent;
        int         mode;
        int         burst_len;
        int         focus;
        int         pick;
        logic [1:0] op;
        logic [2:0] prio;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        send_op(OP_DEQUEUE, 8'h00, 3'd0);   // every level empty
        send_op(OP_RESTORE, 8'hFF, 3'd7);   // pending empty
        send_op(OP_ENQUEUE, 8'h00, 3'd0);
        send_op(OP_ENQUEUE, 8'hFF, 3'd3);
        send_op(OP_ENQUEUE, 8'hAA, 3'd4);   // bad priority
        send_op(OP_ENQUEUE, 8'h55, 3'd7);   // bad priority
        send_op(OP_ENQUEUE, 8'h12, 3'd1);
        send_op(OP_DEQUEUE, 8'h00, 3'd0);
        send_op(OP_DEQUEUE, 8'hFF, 3'd7);
        send_op(OP_DEQUEUE, 8'h00, 3'd0);
        send_op(OP_MOVE,    8'h81, 3'd2);
        send_op(OP_MOVE,    8'h7E, 3'd7);   // moves take any priority
        send_op(OP_MOVE,    8'h3C, 3'd5);
        send_op(OP_MOVE,    8'hFF, 3'd0);
        send_op(OP_RESTORE, 8'h00, 3'd0);
        send_op(OP_RESTORE, 8'h00, 3'd0);   // dropped, bad priority
        send_op(OP_RESTORE, 8'h00, 3'd0);   // dropped, bad priority
        send_op(OP_RESTORE, 8'h00, 3'd0);
        send_op(OP_DEQUEUE, 8'h00, 3'd0);
        send_op(OP_DEQUEUE, 8'h00, 3'd0);
        send_op(OP_DEQUEUE, 8'h00, 3'd0);   // every level empty again
        send_op(OP_RESTORE, 8'h00, 3'd0);

        // random bursts: fill one level and pending, drain, or mixed
        sent = 0;
        while (sent < 1800)
        begin
            mode      = $urandom_range(0, 3);
            burst_len = $urandom_range(8, 40);
            focus     = $urandom_range(0, NUM_LEVELS - 1);
            steady    = ($urandom_range(0, 4) == 0);
            repeat (burst_len)
            begin
                pick = $urandom_range(0, 9);
                case (mode)
                    0:
                        op = (pick < 6) ? OP_ENQUEUE : (pick < 9) ? OP_MOVE : OP_RESTORE;
                    1:
                        op = (pick < 5) ? OP_DEQUEUE : (pick < 9) ? OP_RESTORE : OP_ENQUEUE;
                    default:
                        op = 2'($urandom_range(0, 3));
                endcase
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    prio = 3'($urandom_range(0, 7));
                else if (mode == 0 && pick < 8)
                    prio = 3'(focus);
                else
                    prio = 3'($urandom_range(0, NUM_LEVELS - 1));
                send_op(op, 8'($urandom_range(0, 255)), prio);
                sent++;
            end
        end
        req_valid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

### priority_task_queue_unit.f
design/ptq_pkg.sv
design/ptq_ram.sv
design/priority_task_queue_unit.sv
tb/sv/ptq_checker.sv
tb/sv/tb.sv
